@@ rtl/minifloat_add_sub_mul_neg_defines.svh @@
// Assertion macros for the minifloat arithmetic unit.
// Included by the top-level module, which carries the concurrent assertions.
`ifndef MINIFLOAT_ADD_SUB_MUL_NEG_DEFINES_SVH
`define MINIFLOAT_ADD_SUB_MUL_NEG_DEFINES_SVH
`ifndef SYNTHESIS
`define MF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define MF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define MF_ASSERT(label, clk, rst_n, prop)
`define MF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/mfasm_pkg.sv @@
// Package for the minifloat arithmetic unit: operation codes and format constants.
// No dependencies.
package mfasm_pkg;
	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_NEG = 2'd3
	} func_t;

	localparam logic [8:0] SIGN_BIT  = 9'h100;
	localparam logic [8:0] INF_MAG   = 9'h0e0;
	localparam logic [8:0] NAN_CANON = 9'h0e1;
	localparam int unsigned MAG_W = 22;

	typedef logic [MAG_W-1:0] mag_t;

	function automatic logic is_nan(input logic [8:0] v);
		return (v[7:5] == 3'd7) && (v[4:0] != 5'd0);
	endfunction

	function automatic logic is_inf(input logic [8:0] v);
		return v[7:0] == INF_MAG[7:0];
	endfunction

	function automatic logic [5:0] sig_of(input logic [8:0] v);
		return {(v[7:5] != 3'd0), v[4:0]};
	endfunction

	function automatic logic [2:0] eff_exp(input logic [8:0] v);
		return (v[7:5] != 3'd0) ? v[7:5] : 3'd1;
	endfunction

	// Magnitude in units of 2^-14.
	function automatic mag_t mag14(input logic [8:0] v);
		return mag_t'(sig_of(v)) << ({1'b0, eff_exp(v)} + 4'd6);
	endfunction

	// Truncating pack of magnitude x with sign s.
	function automatic logic [8:0] pack(input logic s, input mag_t x);
		logic [4:0] p;
		logic [2:0] e;
		logic [4:0] f;
		p = 5'd0;
		e = 3'd0;
		f = 5'd0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) begin
				p = 5'(i);
			end
		end
		if (x == '0) begin
			return {s, 8'd0};
		end else if (p >= 5'd18) begin
			return {s, INF_MAG[7:0]};
		end else if (p >= 5'd12) begin
			e = 3'(p - 5'd11);
			f = 5'((x >> (p - 5'd5)));
			return {s, e, f};
		end else begin
			return {s, 3'd0, x[11:7]};
		end
	endfunction
endpackage

@@ rtl/mfasm_core.sv @@
// Combinational datapath of the minifloat unit: add, subtract, multiply, negate.
// Depends on mfasm_pkg.
module mfasm_core (
	input  logic [1:0] func,
	input  logic [8:0] operand_a,
	input  logic [8:0] operand_b,
	output logic [8:0] result
);
	logic [8:0] b_eff;
	logic       sa, sb, sm;
	mfasm_pkg::mag_t ma, mb;
	logic [11:0] prod;
	logic [8:0]  add_r, mul_r;

	always_comb begin
		b_eff = (mfasm_pkg::func_t'(func) == mfasm_pkg::FUNC_SUB) ?
			(operand_b ^ mfasm_pkg::SIGN_BIT) : operand_b;
		sa = operand_a[8];
		sb = b_eff[8];
		ma = mfasm_pkg::mag14(operand_a);
		mb = mfasm_pkg::mag14(b_eff);
		if (mfasm_pkg::is_nan(operand_a) || mfasm_pkg::is_nan(b_eff)) begin
			add_r = mfasm_pkg::NAN_CANON;
		end else if (mfasm_pkg::is_inf(operand_a) && mfasm_pkg::is_inf(b_eff)) begin
			add_r = (sa == sb) ? operand_a : mfasm_pkg::NAN_CANON;
		end else if (mfasm_pkg::is_inf(operand_a)) begin
			add_r = operand_a;
		end else if (mfasm_pkg::is_inf(b_eff)) begin
			add_r = b_eff;
		end else if (sa == sb) begin
			add_r = mfasm_pkg::pack(sa, ma + mb);
		end else if (ma > mb) begin
			add_r = mfasm_pkg::pack(sa, ma - mb);
		end else if (mb > ma) begin
			add_r = mfasm_pkg::pack(sb, mb - ma);
		end else begin
			add_r = 9'd0;
		end
	end

	always_comb begin
		sm = operand_a[8] ^ operand_b[8];
		prod = 12'(mfasm_pkg::sig_of(operand_a)) * 12'(mfasm_pkg::sig_of(operand_b));
		if (mfasm_pkg::is_nan(operand_a) || mfasm_pkg::is_nan(operand_b)) begin
			mul_r = mfasm_pkg::NAN_CANON;
		end else if (mfasm_pkg::is_inf(operand_a) || mfasm_pkg::is_inf(operand_b)) begin
			if ((!mfasm_pkg::is_inf(operand_a) && mfasm_pkg::sig_of(operand_a) == 6'd0) ||
			    (!mfasm_pkg::is_inf(operand_b) && mfasm_pkg::sig_of(operand_b) == 6'd0)) begin
				mul_r = mfasm_pkg::NAN_CANON;
			end else begin
				mul_r = {sm, mfasm_pkg::INF_MAG[7:0]};
			end
		end else begin
			mul_r = mfasm_pkg::pack(sm, mfasm_pkg::mag_t'(prod) <<
				(4'(mfasm_pkg::eff_exp(operand_a)) + 4'(mfasm_pkg::eff_exp(operand_b)) - 4'd2));
		end
	end

	always_comb begin
		case (mfasm_pkg::func_t'(func))
			mfasm_pkg::FUNC_MUL: result = mul_r;
			mfasm_pkg::FUNC_NEG: result = operand_a ^ mfasm_pkg::SIGN_BIT;
			default:             result = add_r;
		endcase
	end
endmodule

@@ rtl/minifloat_add_sub_mul_neg.sv @@
// Top level of the minifloat arithmetic unit: input register, datapath, result register.
// Depends on mfasm_pkg, mfasm_core and the assertion macro header.
//
// Usage: an input transaction (func, operand_a, operand_b) is taken when
// in_valid and in_ready are both high. After acceptance the operands sit in
// the input stage registers and pass through the combinational datapath
// into the result register when that stage advances; out_valid rises when
// the result register is loaded. The block is a two-stage pipeline and
// sustains one transaction per cycle while out_ready stays high. Each stage
// advances when the stage after it is empty or being emptied, so a stalled
// receiver holds the result and the pipeline fills, after which in_ready
// falls until out_ready returns. Reset clears both valid bits; no result is
// pending after reset.
`include "minifloat_add_sub_mul_neg_defines.svh"
module minifloat_add_sub_mul_neg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [8:0] operand_a,
	input  logic [8:0] operand_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [8:0] result
);
	logic       vld_s1;
	logic [1:0] func_s1;
	logic [8:0] a_s1, b_s1;
	logic [8:0] res_c;
	logic [8:0] res_s2;
	logic       vld_s2;
	logic       adv_s2;

	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	mfasm_core u_core (
		.func      (func_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.result    (res_c)
	);

	assign out_valid = vld_s2;
	assign result    = res_s2;

	`MF_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result))
	`MF_ASSERT_NEXT(a_fill, clk, arst_n, in_valid && in_ready, vld_s1)
	`MF_ASSERT(a_stall, clk, arst_n, !in_ready |-> (vld_s1 && vld_s2 && !out_ready))
endmodule
